>>> hdl/feature_persistence_alarm_top_macros.svh
// ----------------------------------------------------------------------------
// Feature persistence alarm assertion macros
// Shared assertion forms for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef FEATURE_PERSISTENCE_ALARM_TOP_MACROS_SVH
`define FEATURE_PERSISTENCE_ALARM_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpa assertion failed");

// Next-cycle implication, checked outside reset.
`define FPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpa assertion failed");

// Next-cycle implication that is also checked while reset is applied.
`define FPA_ASSERT_ALW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpa assertion failed");

`endif

>>> hdl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Feature persistence alarm package
// Types, register map and fixed limits shared by the alarm modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int NUM_MEASURES = 7;
  localparam int NUM_CONDS    = 8;

  localparam logic [2:0] REG_SMOOTH_ALPHA = 3'd0;
  localparam logic [2:0] REG_HOLD_FRAMES  = 3'd1;
  localparam logic [2:0] REG_EYE_CLOSED   = 3'd2;
  localparam logic [2:0] REG_EYE_WIDE     = 3'd3;
  localparam logic [2:0] REG_YAW_LOW      = 3'd4;
  localparam logic [2:0] REG_YAW_HIGH     = 3'd5;
  localparam logic [2:0] REG_ROLL         = 3'd6;
  localparam logic [2:0] REG_FROWN_LOW    = 3'd7;

  localparam logic [8:0]  RST_SMOOTH_ALPHA = 9'd102;
  localparam logic [7:0]  RST_HOLD_FRAMES  = 8'd15;
  localparam logic [15:0] RST_EYE_CLOSED   = 16'd737;
  localparam logic [15:0] RST_EYE_WIDE     = 16'd1434;
  localparam logic [15:0] RST_YAW_LOW      = 16'd2867;
  localparam logic [15:0] RST_YAW_HIGH     = 16'd6349;
  localparam logic [14:0] RST_ROLL         = 15'd1280;
  localparam logic [15:0] RST_FROWN_LOW    = 16'd3523;

  localparam logic [8:0]  ALPHA_FULL  = 9'd256;
  localparam logic [15:0] JAW_LIMIT   = 16'd1843;
  localparam logic [15:0] SMILE_LIMIT = 16'd2458;
  localparam logic [15:0] ASYM_LIMIT  = 16'd1280;
  localparam logic [7:0]  RUN_MAX     = 8'd255;

  localparam logic [3:0] WARN_NONE = 4'd0;
  localparam logic [3:0] WARN_GAZE = 4'd1;

  typedef logic signed [16:0] meas_t;

  typedef struct packed {
    logic [7:0]  hold_frames;
    logic [15:0] eye_closed;
    logic [15:0] eye_wide;
    logic [15:0] yaw_low;
    logic [15:0] yaw_high;
    logic [14:0] roll;
    logic [15:0] frown_low;
  } fpa_limits_t;

  typedef struct packed {
    logic [15:0] eye;
    logic [15:0] jaw;
    logic [15:0] mouth;
    logic [15:0] frown;
    logic [15:0] tilt;
    logic [15:0] turn;
    logic [15:0] asym;
  } fpa_avgs_t;

  typedef struct packed {
    logic advance;
    logic face;
    logic restart;
  } fpa_ctrl_t;

endpackage

>>> hdl/fpa_ema.sv
// ----------------------------------------------------------------------------
// Feature persistence alarm smoothing lane
// One exponential average with rounding and reload on the first frame.
// ----------------------------------------------------------------------------
module fpa_ema import fpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       reload,
  input  logic [8:0] alpha,
  input  meas_t      raw,
  output meas_t      avg_nxt
);

  meas_t              avg_r;
  logic [8:0]         wt_old;
  logic signed [26:0] p_old;
  logic signed [26:0] p_new;
  logic signed [27:0] sum;

  assign wt_old = ALPHA_FULL - alpha;
  assign p_old  = avg_r * $signed({1'b0, wt_old});
  assign p_new  = raw * $signed({1'b0, alpha});
  assign sum    = 28'(p_old) + 28'(p_new) + 28'sd128;

  always_comb begin
    if (reload) begin
      avg_nxt = raw;
    end else begin
      avg_nxt = sum[24:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (load) begin
      avg_r <= avg_nxt;
    end
  end

endmodule

>>> hdl/fpa_runs.sv
// ----------------------------------------------------------------------------
// Feature persistence alarm run counters
// Threshold tests, saturating run counters and warning priority.
// ----------------------------------------------------------------------------
module fpa_runs import fpa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fpa_ctrl_t   ctrl,
  input  fpa_avgs_t   avgs,
  input  fpa_limits_t lim,
  output logic [3:0]  warning,
  output logic [7:0]  mask
);

  logic [7:0]  cnt_r   [NUM_CONDS];
  logic [7:0]  cnt_nxt [NUM_CONDS];
  logic [NUM_CONDS-1:0] cond;
  logic [16:0] tilt_ext;
  logic [16:0] tilt_abs;
  logic [7:0]  base;

  assign tilt_ext = {avgs.tilt[15], avgs.tilt};
  assign tilt_abs = tilt_ext[16] ? (17'd0 - tilt_ext) : tilt_ext;

  always_comb begin
    cond[0] = (avgs.turn < lim.yaw_low) || (avgs.turn > lim.yaw_high);
    cond[1] = tilt_abs > {2'b00, lim.roll};
    cond[2] = (avgs.eye > lim.eye_closed) && (avgs.frown < lim.frown_low);
    cond[3] = avgs.eye > lim.eye_wide;
    cond[4] = avgs.eye < lim.eye_closed;
    cond[5] = avgs.jaw > JAW_LIMIT;
    cond[6] = !cond[0] && (avgs.asym > ASYM_LIMIT);
    cond[7] = avgs.mouth < SMILE_LIMIT;
  end

  always_comb begin
    for (int k = 0; k < NUM_CONDS; k++) begin
      base = ctrl.restart ? 8'd0 : cnt_r[k];
      if (!ctrl.face || !cond[k]) begin
        cnt_nxt[k] = 8'd0;
      end else if (base == RUN_MAX) begin
        cnt_nxt[k] = RUN_MAX;
      end else begin
        cnt_nxt[k] = base + 8'd1;
      end
    end
  end

  always_comb begin
    mask    = '0;
    warning = WARN_NONE;
    for (int k = NUM_CONDS - 1; k >= 0; k--) begin
      if (cnt_nxt[k] > lim.hold_frames) begin
        mask[k] = 1'b1;
        warning = 4'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CONDS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (ctrl.advance) begin
      for (int k = 0; k < NUM_CONDS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

endmodule

>>> hdl/feature_persistence_alarm_top.sv
// ----------------------------------------------------------------------------
// Feature persistence alarm
// Smooths seven face measures per frame and raises persistent warnings.
// ----------------------------------------------------------------------------
// The input channel takes one frame per transaction: the face and restart
// flags and seven raw measures. The output channel returns one transaction
// per frame with the warning code, the tracking flag and the active mask.
// A frame is held in an input register, and once the output register is
// free or being read, the smoothing multiply-add, the threshold tests and
// the run counters update together and load the output register. A new
// frame is accepted every cycle while the receiver does not stall. That
// rate is set by the loop from the stored averages and run counters
// through the multiply-add and compares back to themselves.
// When the receiver stalls, the pending result holds in the output register
// and one more frame waits in the input register before in_ready drops.
// Reset empties both registers, zeroes the averages and counters, loads the
// configuration defaults and marks the averages for reload on the next
// tracked frame. Configuration is written over the APB-style port.
// ----------------------------------------------------------------------------
module feature_persistence_alarm_top import fpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_face_found,
  input  logic               in_restart,
  input  logic [15:0]        in_eye_open,
  input  logic [15:0]        in_jaw_open,
  input  logic [15:0]        in_mouth_width,
  input  logic [15:0]        in_frown_level,
  input  logic signed [15:0] in_tilt_angle,
  input  logic [15:0]        in_turn_ratio,
  input  logic [15:0]        in_lip_asymmetry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_warning,
  output logic               out_tracking,
  output logic [7:0]         out_active_mask,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [8:0]  alpha_r;
  fpa_limits_t lim_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic        s1_valid_r;
  logic        s1_face_r;
  logic        s1_restart_r;
  logic [15:0] s1_eye_r;
  logic [15:0] s1_jaw_r;
  logic [15:0] s1_mouth_r;
  logic [15:0] s1_frown_r;
  logic [15:0] s1_tilt_r;
  logic [15:0] s1_turn_r;
  logic [15:0] s1_asym_r;

  logic        reload_pending_r;
  logic        out_valid_r;
  logic [3:0]  warning_r;
  logic        tracking_r;
  logic [7:0]  mask_r;

  logic        advance;
  logic        accept;
  logic [8:0]  alpha_eff;
  logic        reload;
  logic        lane_load;
  meas_t       raw    [NUM_MEASURES];
  meas_t       avg_nxt[NUM_MEASURES];
  fpa_avgs_t   avgs;
  fpa_ctrl_t   ctrl;
  logic [3:0]  warning_nxt;
  logic [7:0]  mask_nxt;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r           <= RST_SMOOTH_ALPHA;
      lim_r.hold_frames <= RST_HOLD_FRAMES;
      lim_r.eye_closed  <= RST_EYE_CLOSED;
      lim_r.eye_wide    <= RST_EYE_WIDE;
      lim_r.yaw_low     <= RST_YAW_LOW;
      lim_r.yaw_high    <= RST_YAW_HIGH;
      lim_r.roll        <= RST_ROLL;
      lim_r.frown_low   <= RST_FROWN_LOW;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SMOOTH_ALPHA: alpha_r           <= pwdata[8:0];
        REG_HOLD_FRAMES:  lim_r.hold_frames <= pwdata[7:0];
        REG_EYE_CLOSED:   lim_r.eye_closed  <= pwdata[15:0];
        REG_EYE_WIDE:     lim_r.eye_wide    <= pwdata[15:0];
        REG_YAW_LOW:      lim_r.yaw_low     <= pwdata[15:0];
        REG_YAW_HIGH:     lim_r.yaw_high    <= pwdata[15:0];
        REG_ROLL:         lim_r.roll        <= pwdata[14:0];
        REG_FROWN_LOW:    lim_r.frown_low   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SMOOTH_ALPHA: prdata = {23'd0, alpha_r};
      REG_HOLD_FRAMES:  prdata = {24'd0, lim_r.hold_frames};
      REG_EYE_CLOSED:   prdata = {16'd0, lim_r.eye_closed};
      REG_EYE_WIDE:     prdata = {16'd0, lim_r.eye_wide};
      REG_YAW_LOW:      prdata = {16'd0, lim_r.yaw_low};
      REG_YAW_HIGH:     prdata = {16'd0, lim_r.yaw_high};
      REG_ROLL:         prdata = {17'd0, lim_r.roll};
      REG_FROWN_LOW:    prdata = {16'd0, lim_r.frown_low};
      default:          prdata = '0;
    endcase
  end

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_face_r    <= in_face_found;
      s1_restart_r <= in_restart;
      s1_eye_r     <= in_eye_open;
      s1_jaw_r     <= in_jaw_open;
      s1_mouth_r   <= in_mouth_width;
      s1_frown_r   <= in_frown_level;
      s1_tilt_r    <= in_tilt_angle;
      s1_turn_r    <= in_turn_ratio;
      s1_asym_r    <= in_lip_asymmetry;
    end
  end

  assign alpha_eff = (alpha_r > ALPHA_FULL) ? ALPHA_FULL : alpha_r;
  assign reload    = reload_pending_r || s1_restart_r;
  assign lane_load = advance && s1_face_r;

  assign raw[0] = {1'b0, s1_eye_r};
  assign raw[1] = {1'b0, s1_jaw_r};
  assign raw[2] = {1'b0, s1_mouth_r};
  assign raw[3] = {1'b0, s1_frown_r};
  assign raw[4] = {s1_tilt_r[15], s1_tilt_r};
  assign raw[5] = {1'b0, s1_turn_r};
  assign raw[6] = {1'b0, s1_asym_r};

  for (genvar g = 0; g < NUM_MEASURES; g++) begin : g_lane
    fpa_ema u_ema (
      .clk     (clk),
      .rst_n   (rst_n),
      .load    (lane_load),
      .reload  (reload),
      .alpha   (alpha_eff),
      .raw     (raw[g]),
      .avg_nxt (avg_nxt[g])
    );
  end

  assign avgs.eye   = avg_nxt[0][15:0];
  assign avgs.jaw   = avg_nxt[1][15:0];
  assign avgs.mouth = avg_nxt[2][15:0];
  assign avgs.frown = avg_nxt[3][15:0];
  assign avgs.tilt  = avg_nxt[4][15:0];
  assign avgs.turn  = avg_nxt[5][15:0];
  assign avgs.asym  = avg_nxt[6][15:0];

  assign ctrl.advance = advance;
  assign ctrl.face    = s1_face_r;
  assign ctrl.restart = s1_restart_r;

  fpa_runs u_runs (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .avgs    (avgs),
    .lim     (lim_r),
    .warning (warning_nxt),
    .mask    (mask_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_pending_r <= 1'b1;
    end else if (advance) begin
      reload_pending_r <= !s1_face_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      warning_r  <= s1_face_r ? warning_nxt : WARN_NONE;
      tracking_r <= s1_face_r;
      mask_r     <= s1_face_r ? mask_nxt : 8'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_warning     = warning_r;
  assign out_tracking    = tracking_r;
  assign out_active_mask = mask_r;

endmodule

>>> hdl/fpa_checker.sv
// ----------------------------------------------------------------------------
// Feature persistence alarm port checker
// Watches the top-level ports for consistent results and a clean reset.
// ----------------------------------------------------------------------------
`include "feature_persistence_alarm_top_macros.svh"

module fpa_checker import fpa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_warning,
  input logic       out_tracking,
  input logic [7:0] out_active_mask
);

  `FPA_ASSERT_IMP(a_lost_quiet, out_valid && !out_tracking, out_warning == WARN_NONE && out_active_mask == 8'd0)
  `FPA_ASSERT_IMP(a_warn_mask, out_valid, (out_warning == WARN_NONE) == (out_active_mask == 8'd0))
  `FPA_ASSERT_IMP(a_gaze_first, out_valid && out_active_mask[0], out_warning == WARN_GAZE)
  `FPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_warning) && $stable(out_active_mask))
  `FPA_ASSERT_ALW(a_reset_empty, !rst_n, !out_valid)

endmodule

bind feature_persistence_alarm_top fpa_checker u_fpa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_warning     (out_warning),
  .out_tracking    (out_tracking),
  .out_active_mask (out_active_mask)
);
